// ----- sv/htlp_pkg.sv -----
`timescale 1ns / 1ps
package htlp_pkg;

  // table depth must stay a power of two: the home slot is the low key bits
  localparam int TABLE_SIZE  = 1024;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int VALUE_WIDTH = 32;
  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 1 + VALUE_WIDTH + KEY_W;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;

  typedef struct packed {
    logic                   occ;
    logic [VALUE_WIDTH-1:0] value;
    logic [KEY_W-1:0]       key;
  } slot_t;

  // outcome of one probe step
  typedef struct packed {
    logic occ;
    logic hit;
    idx_t next_idx;
    logic wrapped;
  } probe_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctl_stat_t;

endpackage

// ----- sv/htlp_ram.sv -----
`timescale 1ns / 1ps
module htlp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/htlp_probe.sv -----
`timescale 1ns / 1ps
module htlp_probe
  import htlp_pkg::*;
(
  input  slot_t            slot,
  input  logic [KEY_W-1:0] key,
  input  idx_t             idx,
  input  idx_t             home,
  output probe_t           pr
);

  idx_t next_idx;

  // step forward with wrap from the last slot to slot 0
  always_comb begin
    if (idx == idx_t'(TABLE_SIZE - 1)) begin
      next_idx = '0;
    end else begin
      next_idx = idx + 1'b1;
    end
  end

  assign pr.occ      = slot.occ;
  assign pr.hit      = (slot.key == key);
  assign pr.next_idx = next_idx;
  assign pr.wrapped  = (next_idx == home);

endmodule

// ----- sv/htlp_ctrl.sv -----
`timescale 1ns / 1ps
module htlp_ctrl
  import htlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic [31:0]      in_value,
  input  slot_t            rd_slot,
  input  probe_t           pr,
  output logic             rd_en,
  output idx_t             rd_addr,
  output logic             wr_en,
  output idx_t             wr_addr,
  output slot_t            wr_data,
  output logic [KEY_W-1:0] key_q,
  output idx_t             idx_q,
  output idx_t             home_q,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output ctl_stat_t        stat
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  state_t                 state, state_next;
  idx_t                   clr_cnt;
  idx_t                   idx_next;
  logic                   op_q;
  logic [VALUE_WIDTH-1:0] val_q;

  always_comb begin
    state_next = state;
    idx_next   = idx_q;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = '{occ: 1'b1, value: val_q, key: key_q};
    res_valid  = 1'b0;
    res.status = ST_MISSING;
    res.value  = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '{occ: 1'b0, value: val_q, key: key_q};
        if (clr_cnt == idx_t'(TABLE_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = in_key[IDX_W-1:0];
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (op_q == OP_INSERT) begin
          if (!pr.occ || pr.hit) begin
            res_valid  = 1'b1;
            res.status = pr.occ ? ST_UPDATED : ST_INSERTED;
            if (res_ready) begin
              wr_en      = 1'b1;
              state_next = S_IDLE;
            end
          end else if (pr.wrapped) begin
            res_valid  = 1'b1;
            res.status = ST_FULL;
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end else begin
            rd_en    = 1'b1;
            rd_addr  = pr.next_idx;
            idx_next = pr.next_idx;
          end
        end else begin
          if (!pr.occ) begin
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end else if (pr.hit) begin
            res_valid  = 1'b1;
            res.status = ST_FOUND;
            res.value  = 32'(rd_slot.value);
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end else if (pr.wrapped) begin
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end else begin
            rd_en    = 1'b1;
            rd_addr  = pr.next_idx;
            idx_next = pr.next_idx;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= in_op;
      key_q  <= in_key;
      val_q  <= VALUE_WIDTH'(in_value);
      idx_q  <= in_key[IDX_W-1:0];
      home_q <= in_key[IDX_W-1:0];
    end else begin
      idx_q <= idx_next;
    end
  end

  assign stat.clearing = (state == S_CLEAR);
  assign stat.busy     = (state == S_PROBE);

endmodule

// ----- sv/hash_table_linear_probe.sv -----
`timescale 1ns / 1ps
// channel  dir  tdata                                  tuser
// s_axis   in   [63:0] key, [95:64] value_in           [0] op (0 insert, 1 find)
// m_axis   out  [31:0] value_out                       [2:0] status
//
// a transaction reads its home slot first, then the slots after it in turn:
// the single slot memory read port gives one probe per cycle
// the last probe's result lands in the output register once that register is free
// after reset a clearing pass writes every slot empty, and s_tready stays
// low meanwhile
// a stalled result holds the last probe; the next transaction can be taken
// while a finished result still waits in the output register
module hash_table_linear_probe
  import htlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // key [63:0], value_in [95:64]
  input  logic [0:0]  s_tuser,   // op [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_out [31:0]
  output logic [2:0]  m_tuser    // status [2:0]
);

  // slot memory interface
  logic             rd_en;
  idx_t             rd_addr;
  logic [SLOT_W-1:0] rd_word;
  logic             wr_en;
  idx_t             wr_addr;
  slot_t            wr_data;
  slot_t            rd_slot;

  // probe datapath
  logic [KEY_W-1:0] key_q;
  idx_t             idx_q;
  idx_t             home_q;
  probe_t           pr;

  // result handoff
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  ctl_stat_t        stat;

  assign rd_slot = slot_t'(rd_word);

  // key, value and occupied flag share one word per slot
  htlp_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // key compare and next slot for the slot just read
  htlp_probe u_probe (
    .slot (rd_slot),
    .key  (key_q),
    .idx  (idx_q),
    .home (home_q),
    .pr   (pr)
  );

  // sequencer: clearing pass, accept, probe loop, result
  htlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_key    (s_tdata[63:0]),
    .in_value  (s_tdata[95:64]),
    .rd_slot   (rd_slot),
    .pr        (pr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .key_q     (key_q),
    .idx_q     (idx_q),
    .home_q    (home_q),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .stat      (stat)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= res.value;
    end
  end

  // no input is taken while clearing or probing
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (stat.clearing || stat.busy) |-> !s_tready)
    else $error("input accepted while sequencer busy");

  // a slot is only filled in the cycle its result is handed off
  a_fill_with_result: assert property (@(posedge clk) disable iff (rst)
    (wr_en && wr_data.occ) |-> (res_valid && res_ready))
    else $error("slot written without a result transaction");

  // value_out is zero for every status but found
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_FOUND)) |-> (m_tdata == 32'd0))
    else $error("nonzero value_out on a non-found status");

endmodule

// ----- test/hash_table_linear_probe_tb.sv -----
`timescale 1ns / 1ps
module hash_table_linear_probe_tb;
  import htlp_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;    // key [63:0], value_in [95:64]
  logic [0:0]  s_tuser  = '0;    // op [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // value_out [31:0]
  logic [2:0]  m_tuser;          // status [2:0]

  // shadow copy of the slot memory, updated in transaction order
  logic [KEY_W-1:0]       shadow_key   [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0] shadow_value [TABLE_SIZE];
  bit                     shadow_occ   [TABLE_SIZE];

  result_t          pending_results[$];
  logic [KEY_W-1:0] stored_keys[$];     // keys known to be in the table
  int               mismatches = 0;
  bit               idle_en    = 1'b1;
  int               stall_left = 0;

  hash_table_linear_probe u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // walk the shadow table from the home slot, as the block does, and
  // apply an insert in place
  function automatic result_t probe_shadow_table(logic op, logic [KEY_W-1:0] key,
                                                 logic [31:0] value_in);
    result_t res;
    idx_t    slot;
    int      probes;
    slot      = idx_t'(key % TABLE_SIZE);
    probes    = 0;
    res.value = '0;
    while (probes < TABLE_SIZE && shadow_occ[slot] && shadow_key[slot] != key) begin
      slot = (slot == TABLE_SIZE - 1) ? '0 : slot + 1'b1;
      probes++;
    end
    if (probes == TABLE_SIZE) begin
      // came back to the home slot: every slot holds another key
      res.status = (op == OP_FIND) ? ST_MISSING : ST_FULL;
    end else if (op == OP_FIND) begin
      res.status = shadow_occ[slot] ? ST_FOUND : ST_MISSING;
      if (shadow_occ[slot])
        res.value = shadow_value[slot];
    end else begin
      res.status          = shadow_occ[slot] ? ST_UPDATED : ST_INSERTED;
      shadow_key[slot]    = key;
      shadow_value[slot]  = value_in;
      shadow_occ[slot]    = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] key_at(idx_t home);
    logic [KEY_W-1:0] key;
    key            = {$urandom, $urandom};
    key[IDX_W-1:0] = home;
    return key;
  endfunction

  // half the keys land in a hot window across the wrap point to build
  // long probe chains
  function automatic logic [KEY_W-1:0] random_key();
    idx_t home;
    if ($urandom_range(0, 1))
      home = idx_t'(1000 + $urandom_range(0, 47));
    else
      home = idx_t'($urandom);
    return key_at(home);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key(idx_t home);
    logic [KEY_W-1:0] key;
    bit               seen;
    do begin
      key  = key_at(home);
      seen = 1'b0;
      foreach (shadow_occ[j])
        if (shadow_occ[j] && shadow_key[j] == key)
          seen = 1'b1;
    end while (seen);
    return key;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [31:0] value_in);
    result_t res;
    res = probe_shadow_table(op, key, value_in);
    pending_results = {pending_results, res};
    if (op == OP_INSERT && res.status == ST_INSERTED)
      stored_keys = {stored_keys, key};
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value_in, key};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // result side back-pressure in random bursts, off once idle_en is cleared
  always @(negedge clk) begin
    if (!idle_en) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (m_tvalid === 1'b1 && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d value %h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata !== want.value) begin
          $display("%0t: value_out mismatch: expected %h, actual %h",
                   $time, want.value, m_tdata);
          mismatches++;
        end
      end
    end
  end

  // empty table, extreme keys and values, overwrite in place
  task automatic test_directed_basics();
    send_item(OP_FIND,   64'h0, 32'h0);
    send_item(OP_INSERT, 64'h0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_item(OP_FIND,   64'h0, 32'h0);
    send_item(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'h0, 32'h5A5A_A5A5);
    send_item(OP_FIND,   64'h0, 32'h1234_5678);
    send_item(OP_FIND,   64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF);
  endtask

  // keys sharing the last home slot chain across the wrap to slot 0
  task automatic test_collisions_and_wrap();
    send_item(OP_INSERT, 64'h7FF, 32'hA000_0001);
    send_item(OP_INSERT, 64'hBFF, 32'hA000_0002);
    send_item(OP_FIND,   64'hBFF, 32'h0);
    send_item(OP_FIND,   64'hFFF, 32'h0);
    send_item(OP_INSERT, 64'h1, 32'hA000_0003);
    send_item(OP_FIND,   64'h1, 32'h0);
    send_item(OP_INSERT, 64'h7FF, 32'hC3C3_3C3C);
    send_item(OP_FIND,   64'h7FF, 32'h0);
    send_item(OP_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(OP_FIND,   64'h8000_0000_0000_0000, 32'h0);
    send_item(OP_FIND,   64'hFFF, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_item(OP_INSERT, random_key(), $urandom);
      else if (pick < 60)
        send_item(OP_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                  $urandom);
      else if (pick < 85)
        send_item(OP_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                  $urandom);
      else
        send_item(OP_FIND, random_key(), $urandom);
    end
  endtask

  // drop a key on its own home slot at every empty slot until the table is full
  task automatic test_fill_table();
    for (int j = 0; j < TABLE_SIZE; j++) begin
      if (j == TABLE_SIZE / 2)
        idle_en = 1'b0;
      if (!shadow_occ[j])
        send_item(OP_INSERT, key_at(idx_t'(j)), $urandom);
    end
  endtask

  // every slot taken: new keys are dropped, misses take one full wrap
  task automatic test_full_table();
    logic [KEY_W-1:0] known;
    known = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    send_item(OP_INSERT, fresh_key(idx_t'($urandom)), $urandom);
    send_item(OP_INSERT, fresh_key('0), $urandom);
    send_item(OP_INSERT, known, $urandom);
    send_item(OP_FIND,   known, 32'h0);
    send_item(OP_FIND,   fresh_key(idx_t'(TABLE_SIZE - 1)), $urandom);
    send_item(OP_FIND,   fresh_key(idx_t'($urandom)), 32'h0);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_collisions_and_wrap();
    drain_results();
    test_random_traffic(600);
    test_fill_table();
    test_full_table();
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("hash_table_linear_probe_tb OK");
    else
      $display("hash_table_linear_probe_tb NOT OK");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("hash_table_linear_probe_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
sv/htlp_pkg.sv
sv/htlp_ram.sv
sv/htlp_probe.sv
sv/htlp_ctrl.sv
sv/hash_table_linear_probe.sv
test/hash_table_linear_probe_tb.sv
